// ===== rtl/cpd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpd_pkg : shared types and constants of the command packet deframer
// Byte codes, result kinds, register indexes, the configuration bundle and
// the packed result record shared by the parser, the registers and the top.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned NUM_BODY = 8;   // body byte fields of one result
  localparam int unsigned NUM_REGS = 4;

  // Start and type bytes of the command stream
  localparam logic [BYTE_W-1:0] START_BYTE   = 8'h21;  // '!'
  localparam logic [BYTE_W-1:0] TYPE_COLOR   = 8'h43;  // 'C'
  localparam logic [BYTE_W-1:0] TYPE_BRIGHT  = 8'h56;  // 'V'
  localparam logic [BYTE_W-1:0] TYPE_WHITE   = 8'h57;  // 'W'
  localparam logic [BYTE_W-1:0] TYPE_RAINBOW = 8'h52;  // 'R'

  // Packet kinds as reported on the result
  localparam logic [KIND_W-1:0] KIND_COLOR   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BRIGHT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WHITE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RAINBOW = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_COLOR_LEN   = 2'd0;
  localparam logic [1:0] REG_BRIGHT_LEN  = 2'd1;
  localparam logic [1:0] REG_WHITE_LEN   = 2'd2;
  localparam logic [1:0] REG_RAINBOW_LEN = 2'd3;

  // Reset values of the total packet lengths
  localparam logic [LEN_W-1:0] COLOR_LEN_RST   = 4'd6;
  localparam logic [LEN_W-1:0] BRIGHT_LEN_RST  = 4'd3;
  localparam logic [LEN_W-1:0] WHITE_LEN_RST   = 4'd3;
  localparam logic [LEN_W-1:0] RAINBOW_LEN_RST = 4'd3;

  // Header bytes counted in every total length
  localparam logic [LEN_W-1:0] HEADER_LEN = 4'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [NUM_REGS-1:0][LEN_W-1:0] total_len;  // indexed by packet kind
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]                 kind;
    logic [LEN_W-1:0]                  body_len;
    logic [NUM_BODY-1:0][BYTE_W-1:0]   body;      // body[0] arrived first
  } result_t;

endpackage

// ===== rtl/cpd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cpd_cfg_regs : packet length registers
// Four total-length registers behind a simple APB-style slave, one word
// each, with no wait states.
// ----------------------------------------------------------------------------
module cpd_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cpd_pkg::cfg_t       cfg
);
  import cpd_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_len[REG_COLOR_LEN]   <= COLOR_LEN_RST;
      cfg.total_len[REG_BRIGHT_LEN]  <= BRIGHT_LEN_RST;
      cfg.total_len[REG_WHITE_LEN]   <= WHITE_LEN_RST;
      cfg.total_len[REG_RAINBOW_LEN] <= RAINBOW_LEN_RST;
    end else if (wr_en) begin
      cfg.total_len[reg_idx] <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = {{(32-LEN_W){1'b0}}, cfg.total_len[reg_idx]};

endmodule

// ===== rtl/cpd_parser.sv =====
// ----------------------------------------------------------------------------
// cpd_parser : packet framing state machine
// Steps once per accepted byte: hunts for the start byte, decodes the type
// byte, collects the body and forms at most one result for the byte.
// ----------------------------------------------------------------------------
module cpd_parser #(
  parameter int unsigned MAX_BODY = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               rx_byte,
  input  cpd_pkg::cfg_t            cfg,
  output logic                     res_valid,
  output cpd_pkg::result_t         res
);
  import cpd_pkg::*;

  phase_t                          phase;
  phase_t                          phase_next;
  logic [1:0]                      kind_held;
  logic [LEN_W-1:0]                bytes_needed;
  logic [LEN_W-1:0]                bytes_taken;
  logic [BYTE_W-1:0]               body_store [MAX_BODY];

  logic                            type_ok;
  logic [1:0]                      type_kind;
  logic [LEN_W-1:0]                sel_len;
  logic [LEN_W-1:0]                new_needed;
  logic [LEN_W-1:0]                taken_inc;
  logic                            body_done;
  logic [NUM_BODY-1:0][BYTE_W-1:0] body_view;

  // Type byte decode
  always_comb begin
    type_ok   = 1'b1;
    type_kind = KIND_COLOR[1:0];
    case (rx_byte)
      TYPE_COLOR:   type_kind = KIND_COLOR[1:0];
      TYPE_BRIGHT:  type_kind = KIND_BRIGHT[1:0];
      TYPE_WHITE:   type_kind = KIND_WHITE[1:0];
      TYPE_RAINBOW: type_kind = KIND_RAINBOW[1:0];
      default:      type_ok   = 1'b0;
    endcase
  end

  // Body length of the decoded type: total less header, clipped to the store
  always_comb begin
    sel_len = cfg.total_len[type_kind];
    if (sel_len < HEADER_LEN) begin
      new_needed = '0;
    end else begin
      new_needed = sel_len - HEADER_LEN;
    end
    if (new_needed > LEN_W'(MAX_BODY)) begin
      new_needed = LEN_W'(MAX_BODY);
    end
  end

  assign taken_inc = bytes_taken + LEN_W'(1);
  assign body_done = (taken_inc >= bytes_needed);

  // Result body: stored bytes with the byte now arriving merged in, zero
  // past the packet's length.
  for (genvar k = 0; k < NUM_BODY; k++) begin : g_view
    if (k < MAX_BODY) begin : g_live
      assign body_view[k] = (LEN_W'(k) >= bytes_needed) ? '0 :
                            (LEN_W'(k) == bytes_taken)  ? rx_byte :
                            body_store[k];
    end else begin : g_none
      assign body_view[k] = '0;
    end
  end

  // Next state
  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        PH_TYPE: begin
          if (!type_ok || (new_needed == '0)) begin
            phase_next = PH_HUNT;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          phase_next = body_done ? PH_HUNT : PH_BODY;
        end
        default: begin
          phase_next = (rx_byte == START_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid    = 1'b0;
    res          = '0;
    res.kind     = KIND_INVALID;
    if (step) begin
      case (phase)
        PH_TYPE: begin
          if (!type_ok) begin
            res_valid = 1'b1;
          end else if (new_needed == '0) begin
            res_valid = 1'b1;
            res.kind  = {1'b0, type_kind};
          end
        end
        PH_BODY: begin
          if (body_done) begin
            res_valid    = 1'b1;
            res.kind     = {1'b0, kind_held};
            res.body_len = bytes_needed;
            res.body     = body_view;
          end
        end
        default: begin
          res_valid = (rx_byte != START_BYTE);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      kind_held    <= '0;
      bytes_needed <= '0;
      bytes_taken  <= '0;
    end else begin
      phase <= phase_next;
      if (step && (phase == PH_TYPE) && type_ok) begin
        kind_held    <= type_kind;
        bytes_needed <= new_needed;
        bytes_taken  <= '0;
      end else if (step && (phase == PH_BODY)) begin
        bytes_taken  <= taken_inc;
      end
    end
  end

  for (genvar k = 0; k < MAX_BODY; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (step && (phase == PH_BODY) && (bytes_taken == LEN_W'(k))) begin
        body_store[k] <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/cpd_out_buf.sv =====
// ----------------------------------------------------------------------------
// cpd_out_buf : result output register with skid stage
// Holds the result shown downstream and catches one more while the sink
// stalls, so that the input side keeps a registered ready.
// ----------------------------------------------------------------------------
module cpd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  cpd_pkg::result_t  push_data,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cpd_pkg::result_t  pop_data
);
  import cpd_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;
  assign main_free  = !main_valid || pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push_valid;
      end
    end else if (push_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push_valid) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/command_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// command_packet_deframer : '!'-prefixed command packet deframer
// Frames command packets out of a received byte stream and reports each
// packet, or each discarded byte, as one result transfer.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                      Carries
//   s_*       in         s_tvalid s_tready s_tdata    one received byte
//   m_*       out        m_tvalid m_tready m_tdata    body length and bytes
//                        m_tuser                      packet kind
//   APB       in/out     psel penable pwrite paddr    total packet lengths
//                        pwdata prdata pready
//
// One byte is taken every cycle while s_tready is high. Each accepted byte is processed
// in the cycle it is accepted by the parser state machine; any result it causes is
// registered in the result register, or in the skid stage while the sink stalls.
// s_tready drops only while the skid stage holds a result behind a stalled
// one, so a sink stall reaches the source after one further result.
// Reset (rst, synchronous) returns the parser to hunting for a start byte,
// empties the output stage and restores the default packet lengths.
// ----------------------------------------------------------------------------
module command_packet_deframer #(
  parameter int unsigned MAX_BODY = 8   // body bytes stored, 1 to 8
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] rx_byte
  // packet results out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,     // [3:0] body_len, [11:4] body_0 ... [67:60] body_7,
                                   // [71:68] zero
  output logic [2:0]  m_tuser,     // [2:0] packet_kind
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cpd_pkg::*;

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // A byte is consumed on every transfer of the slave side
  assign step = s_tvalid & s_tready;

  cpd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpd_parser #(
    .MAX_BODY (MAX_BODY)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // The result register and its skid stage decouple the two stream sides;
  // a result is only pushed when the skid stage is empty.
  cpd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (s_tready),
    .pop_valid  (m_tvalid),
    .pop_ready  (m_tready),
    .pop_data   (out_res)
  );

  assign m_tdata = {4'b0000, out_res.body, out_res.body_len};
  assign m_tuser = out_res.kind;

endmodule
